// ===== rtl/i2crm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crm_pkg: shared types and constants of the I2C register master
// Phase codes, byte stage codes, status codes and the channel words.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crm_pkg;

  // Tick counter width default and phase length register
  localparam int unsigned TickCountWidthDef = 16;
  localparam int unsigned PhaseTicksW       = 16;
  localparam logic [PhaseTicksW-1:0] PhaseTicksRst = 16'd10;

  // Line phases of the bit-level sequencer
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST_A     = 5'd1,
    PH_ST_B     = 5'd2,
    PH_ST_C     = 5'd3,
    PH_BIT_LO   = 5'd4,
    PH_BIT_HI   = 5'd5,
    PH_ACK_PRE1 = 5'd6,
    PH_ACK_PRE2 = 5'd7,
    PH_ACK_REL  = 5'd8,
    PH_ACK_HI1  = 5'd9,
    PH_ACK_HI2  = 5'd10,
    PH_ACK_POST = 5'd11,
    PH_RD_LO    = 5'd12,
    PH_RD_HI    = 5'd13,
    PH_SP_A     = 5'd14,
    PH_SP_B     = 5'd15,
    PH_SP_C     = 5'd16
  } phase_e;

  // Which byte of the transaction is on the bus
  typedef enum logic [2:0] {
    STG_ADDR_W = 3'd0,
    STG_REG    = 3'd1,
    STG_DATA   = 3'd2,
    STG_ADDR_R = 3'd3,
    STG_READ   = 3'd4
  } stage_e;

  // Outcome of the last transaction
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ADDR_NAK = 2'd1,
    ST_REG_NAK  = 2'd2,
    ST_DATA_NAK = 2'd3
  } status_e;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Driven line levels
  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

  // Input word: one timebase tick
  typedef struct packed {
    logic       go;
    logic       mode;
    logic [6:0] target_addr;
    logic [7:0] reg_index;
    logic [7:0] write_data;
    logic       sda_in;
  } in_word_t;

  // Result word: line levels and status after the tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } res_word_t;

  typedef logic [PhaseTicksW-1:0] cfg_word_t;

endpackage

`default_nettype wire

// ===== rtl/i2crm_chan_if.sv =====
// ----------------------------------------------------------------------------
// i2crm_chan_if: valid/ready channel
// Carries one word of type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2crm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2c_register_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_register_master_unit: tick-driven I2C master for one register access
// Runs a register write or a register read on a device, one line phase at a
// time, and reports the line levels and status for every tick.
// ----------------------------------------------------------------------------
// Each input word is one timebase tick; the block takes one tick per clock
// cycle and returns exactly one result word per tick, in the cycle after the
// tick is taken, from its result register. A tick is taken whenever the
// result register is empty or its word is being taken in the same cycle,
// so a stall on the result side holds the input side and nothing else.
// The sequencer state (phase, tick counter, shift byte) is updated in the
// same cycle as the tick is taken. phase_ticks sets how many ticks each line
// phase lasts (0 acts as 1, the tick counter width caps it); write it only
// while no transaction is running.
`default_nettype none

module i2c_register_master_unit #(
  parameter int unsigned TICK_COUNT_WIDTH = i2crm_pkg::TickCountWidthDef
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  i2crm_chan_if.sink     in_i,
  i2crm_chan_if.source   res_o,
  i2crm_chan_if.sink     cfg_i
);

  localparam int unsigned CmpW =
    ((TICK_COUNT_WIDTH > i2crm_pkg::PhaseTicksW) ? TICK_COUNT_WIDTH
                                                 : i2crm_pkg::PhaseTicksW) + 1;

  // State
  i2crm_pkg::phase_e                 phase_q, phase_d;
  i2crm_pkg::stage_e                 stage_q, stage_d;
  i2crm_pkg::status_e                status_q, status_d;
  i2crm_pkg::lines_t                 lines_q, lines_d;
  logic [TICK_COUNT_WIDTH-1:0]       tick_q, tick_d;
  logic [3:0]                        bit_q, bit_d;
  logic [7:0]                        shift_q, shift_d;
  logic [7:0]                        rbyte_q, rbyte_d;
  logic                              mode_q, mode_d;
  logic [6:0]                        dev_q, dev_d;
  logic [7:0]                        reg_q, reg_d;
  logic [7:0]                        wdata_q, wdata_d;
  logic                              done_q, done_d;
  logic                              out_valid_q;
  logic [i2crm_pkg::PhaseTicksW-1:0] phase_ticks_q;

  logic                              in_fire;
  logic                              phase_end;
  logic [CmpW-1:0]                   pt_ext, len_raw, len_clip, span, tick_nxt;
  logic [7:0]                        rd_shift;
  logic [3:0]                        rd_bit;
  logic                              tx_bit;

  i2crm_pkg::in_word_t               in_w;

  assign in_w    = in_i.data;
  assign in_i.ready = !out_valid_q || res_o.ready;
  assign in_fire = in_i.valid && in_i.ready;

  // Configuration: always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2crm_pkg::PhaseTicksRst;
    end else if (cfg_i.valid) begin
      phase_ticks_q <= cfg_i.data;
    end
  end

  // Phase length and end-of-phase compare
  always_comb begin
    pt_ext   = CmpW'(phase_ticks_q);
    len_raw  = (pt_ext == '0) ? CmpW'(1) : pt_ext;
    span     = CmpW'(1) << TICK_COUNT_WIDTH;
    len_clip = (len_raw > span) ? span : len_raw;
    tick_nxt = CmpW'(tick_q) + CmpW'(1);
    phase_end = (tick_nxt >= len_clip);
  end

  // Read shift path
  assign rd_shift = {shift_q[6:0], in_w.sda_in};
  assign rd_bit   = bit_q + 4'd1;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    stage_d  = stage_q;
    status_d = status_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    rbyte_d  = rbyte_q;
    mode_d   = mode_q;
    dev_d    = dev_q;
    reg_d    = reg_q;
    wdata_d  = wdata_q;
    done_d   = 1'b0;

    if (phase_q == i2crm_pkg::PH_IDLE) begin
      if (in_w.go) begin
        mode_d  = in_w.mode;
        dev_d   = in_w.target_addr;
        reg_d   = in_w.reg_index;
        wdata_d = in_w.write_data;
        stage_d = i2crm_pkg::STG_ADDR_W;
        shift_d = {in_w.target_addr, 1'b0};
        bit_d   = 4'd0;
        tick_d  = '0;
        phase_d = i2crm_pkg::PH_ST_A;
      end
    end else if (phase_end) begin
      tick_d = '0;
      unique case (phase_q)
        i2crm_pkg::PH_ST_A: phase_d = i2crm_pkg::PH_ST_B;
        i2crm_pkg::PH_ST_B: phase_d = i2crm_pkg::PH_ST_C;
        i2crm_pkg::PH_ST_C: begin
          phase_d = i2crm_pkg::PH_BIT_LO;
          bit_d   = 4'd7;
        end
        i2crm_pkg::PH_BIT_LO: phase_d = i2crm_pkg::PH_BIT_HI;
        i2crm_pkg::PH_BIT_HI: begin
          if (bit_q[2:0] == 3'd0) begin
            phase_d = i2crm_pkg::PH_ACK_PRE1;
          end else begin
            bit_d   = {1'b0, bit_q[2:0] - 3'd1};
            phase_d = i2crm_pkg::PH_BIT_LO;
          end
        end
        i2crm_pkg::PH_ACK_PRE1: phase_d = i2crm_pkg::PH_ACK_PRE2;
        i2crm_pkg::PH_ACK_PRE2: phase_d = i2crm_pkg::PH_ACK_REL;
        i2crm_pkg::PH_ACK_REL:  phase_d = i2crm_pkg::PH_ACK_HI1;
        i2crm_pkg::PH_ACK_HI1: begin
          // sample the slave ACK; the master NACK after a read is not checked
          if (stage_q != i2crm_pkg::STG_READ) begin
            shift_d = {7'd0, in_w.sda_in};
          end
          phase_d = i2crm_pkg::PH_ACK_HI2;
        end
        i2crm_pkg::PH_ACK_HI2: begin
          phase_d = (stage_q == i2crm_pkg::STG_READ) ? i2crm_pkg::PH_SP_A
                                                     : i2crm_pkg::PH_ACK_POST;
        end
        i2crm_pkg::PH_ACK_POST: begin
          if (shift_q[0]) begin
            // missing ACK: abort without a stop
            case (stage_q)
              i2crm_pkg::STG_REG:  status_d = i2crm_pkg::ST_REG_NAK;
              i2crm_pkg::STG_DATA: status_d = i2crm_pkg::ST_DATA_NAK;
              default:             status_d = i2crm_pkg::ST_ADDR_NAK;
            endcase
            phase_d = i2crm_pkg::PH_IDLE;
            done_d  = 1'b1;
          end else if (stage_q == i2crm_pkg::STG_ADDR_W) begin
            stage_d = i2crm_pkg::STG_REG;
            shift_d = reg_q;
            bit_d   = 4'd7;
            phase_d = i2crm_pkg::PH_BIT_LO;
          end else if (stage_q == i2crm_pkg::STG_REG &&
                       mode_q == i2crm_pkg::MODE_WRITE) begin
            stage_d = i2crm_pkg::STG_DATA;
            shift_d = wdata_q;
            bit_d   = 4'd7;
            phase_d = i2crm_pkg::PH_BIT_LO;
          end else if (stage_q == i2crm_pkg::STG_REG) begin
            // repeated start, address with read bit
            stage_d = i2crm_pkg::STG_ADDR_R;
            shift_d = {dev_q, 1'b1};
            phase_d = i2crm_pkg::PH_ST_A;
          end else if (stage_q == i2crm_pkg::STG_ADDR_R) begin
            stage_d = i2crm_pkg::STG_READ;
            shift_d = 8'd0;
            bit_d   = 4'd0;
            phase_d = i2crm_pkg::PH_RD_LO;
          end else begin
            phase_d = i2crm_pkg::PH_SP_A;
          end
        end
        i2crm_pkg::PH_RD_LO: phase_d = i2crm_pkg::PH_RD_HI;
        i2crm_pkg::PH_RD_HI: begin
          shift_d = rd_shift;
          bit_d   = rd_bit;
          if (rd_bit[3]) begin
            rbyte_d = rd_shift;
            phase_d = i2crm_pkg::PH_ACK_REL;
          end else begin
            phase_d = i2crm_pkg::PH_RD_LO;
          end
        end
        i2crm_pkg::PH_SP_A: phase_d = i2crm_pkg::PH_SP_B;
        i2crm_pkg::PH_SP_B: phase_d = i2crm_pkg::PH_SP_C;
        i2crm_pkg::PH_SP_C: begin
          status_d = i2crm_pkg::ST_OK;
          phase_d  = i2crm_pkg::PH_IDLE;
          done_d   = 1'b1;
        end
        default: begin
          phase_d = i2crm_pkg::PH_IDLE;
          done_d  = 1'b1;
        end
      endcase
    end else begin
      tick_d = tick_q + TICK_COUNT_WIDTH'(1);
    end
  end

  // Line levels of the new phase; held while idle
  assign tx_bit = shift_d[bit_d[2:0]];

  always_comb begin
    lines_d = lines_q;
    unique case (phase_d)
      i2crm_pkg::PH_ST_A:     lines_d = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      i2crm_pkg::PH_ST_B:     lines_d = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
      i2crm_pkg::PH_ST_C:     lines_d = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
      i2crm_pkg::PH_BIT_LO:   lines_d = '{scl: 1'b0, sda: tx_bit, drv: 1'b1};
      i2crm_pkg::PH_BIT_HI:   lines_d = '{scl: 1'b1, sda: tx_bit, drv: 1'b1};
      i2crm_pkg::PH_ACK_PRE1: lines_d = '{scl: 1'b0, sda: shift_d[0], drv: 1'b1};
      i2crm_pkg::PH_ACK_PRE2: lines_d = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
      i2crm_pkg::PH_ACK_REL:  lines_d = '{scl: 1'b0, sda: 1'b0, drv: 1'b0};
      i2crm_pkg::PH_ACK_HI1:  lines_d = '{scl: 1'b1, sda: 1'b0, drv: 1'b0};
      i2crm_pkg::PH_ACK_HI2:  lines_d = '{scl: 1'b1, sda: 1'b0, drv: 1'b0};
      i2crm_pkg::PH_ACK_POST: lines_d = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
      i2crm_pkg::PH_RD_LO:    lines_d = '{scl: 1'b0, sda: 1'b0, drv: 1'b0};
      i2crm_pkg::PH_RD_HI:    lines_d = '{scl: 1'b1, sda: 1'b0, drv: 1'b0};
      i2crm_pkg::PH_SP_A:     lines_d = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
      i2crm_pkg::PH_SP_B:     lines_d = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
      i2crm_pkg::PH_SP_C:     lines_d = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      default:                lines_d = lines_q;
    endcase
  end

  // State registers, loaded on each taken tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2crm_pkg::PH_IDLE;
      stage_q  <= i2crm_pkg::STG_ADDR_W;
      status_q <= i2crm_pkg::ST_OK;
      lines_q  <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      tick_q   <= '0;
      bit_q    <= '0;
      shift_q  <= '0;
      rbyte_q  <= '0;
      mode_q   <= 1'b0;
      dev_q    <= '0;
      reg_q    <= '0;
      wdata_q  <= '0;
      done_q   <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      stage_q  <= stage_d;
      status_q <= status_d;
      lines_q  <= lines_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      rbyte_q  <= rbyte_d;
      mode_q   <= mode_d;
      dev_q    <= dev_d;
      reg_q    <= reg_d;
      wdata_q  <= wdata_d;
      done_q   <= done_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word straight from the state registers
  assign res_o.valid          = out_valid_q;
  assign res_o.data.scl_level = lines_q.scl;
  assign res_o.data.sda_level = lines_q.drv & lines_q.sda;
  assign res_o.data.sda_drive = lines_q.drv;
  assign res_o.data.busy_res  = (phase_q != i2crm_pkg::PH_IDLE);
  assign res_o.data.done_res  = done_q;
  assign res_o.data.status    = status_q;
  assign res_o.data.read_data = rbyte_q;

  // Assertions
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> phase_q == i2crm_pkg::PH_IDLE)
    else $error("done flagged while a transaction is still running");

  a_idle_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == i2crm_pkg::PH_IDLE |-> tick_q == '0)
    else $error("tick counter not cleared when idle");

  a_rd_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == i2crm_pkg::PH_RD_LO || phase_q == i2crm_pkg::PH_RD_HI)
      |-> (stage_q == i2crm_pkg::STG_READ && !bit_q[3]))
    else $error("read clock outside the read byte");

  a_tx_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == i2crm_pkg::PH_BIT_LO || phase_q == i2crm_pkg::PH_BIT_HI)
      |-> (stage_q != i2crm_pkg::STG_READ && !bit_q[3]))
    else $error("write bit sent during the read byte");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> $stable(phase_q) && $stable(done_q))
    else $error("state moved while the result word was stalled");

endmodule

`default_nettype wire
